[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: invariant");
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: implication");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/ttt_pkg.sv]
// ----------------------------------------------------------------------------
// Timer task table package
// Command codes, default sizes and the result command shared by the modules.
// ----------------------------------------------------------------------------
package ttt_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int ID_BITS_DEF = 16;
	localparam int MAX_OUT     = 16;
	localparam int NUM_W       = 16;
	localparam int FIRE_W      = $clog2(MAX_OUT + 1);

	typedef enum logic [2:0] {
		K_TICK    = 3'd0,
		K_ADD_ONE = 3'd1,
		K_ADD_PER = 3'd2,
		K_CANCEL  = 3'd3,
		K_CAN_ALL = 3'd4,
		K_CLEAR   = 3'd5
	} kind_t;

	// One request to the result stage per cycle.
	typedef struct packed {
		logic             add_v;
		logic             fire_v;
		logic             flush;
		logic [NUM_W-1:0] number;
	} rpt_cmd_t;

endpackage

[rtl/timer_task_table_unit.sv]
// ----------------------------------------------------------------------------
// Timer task table unit
// Insertion-ordered table of one-shot and periodic timers held in one RAM.
// ----------------------------------------------------------------------------
// Issue a command with start while busy is low. Add one-shot and add periodic
// return the assigned id (0 when the table is full) in the cycle after start.
// Tick, cancel and cancel-all walk the stored entries through the single-port
// read of the entry RAM, one entry per cycle, and a cancel that hits stops
// reading at most one entry past the hit. Fired ids come out in table order,
// at most one beat per cycle, each beat valid only in the cycle strobe is
// high; the receiver cannot stall, so take every beat. The last beat of a
// tick, like the beat of an add, carries last; the last beat of a tick shows
// in the same cycle that busy falls.
// A tick reports at most MAX_OUT fires.
// Entries past the fill count are never read, so no clearing pass follows
// reset: the unit takes commands right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timer_task_table_unit
	import ttt_pkg::*;
#(
	parameter int SLOTS   = SLOTS_DEF,
	parameter int ID_BITS = ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic [30:0]        elapsed,
	input  logic signed [31:0] first_delay,
	input  logic signed [31:0] period,
	input  logic [15:0]        target_id,
	output logic               strobe,
	output logic               result_kind,
	output logic [NUM_W-1:0]   task_number,
	output logic               last
);

	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int EW    = ID_BITS + 66;
	localparam int CW    = (ID_BITS > 16) ? ID_BITS : 16;

	typedef enum logic {S_IDLE, S_WALK} state_t;

	state_t             state_q;
	kind_t              op_q;
	logic [30:0]        elapsed_q;
	logic [15:0]        target_q;
	logic [CNT_W-1:0]   count_q;
	logic [ID_BITS-1:0] next_q;
	logic [CNT_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   dst_q;
	logic               found_q;
	logic [FIRE_W-1:0]  fires_q;
	logic               vld_s1;
	logic [AW-1:0]      src_s1;

	kind_t              in_kind;
	logic               accept;
	logic               full;
	logic               issue;
	logic               proc;
	logic               done;
	logic [ID_BITS-1:0] next_inc;

	logic               we;
	logic [AW-1:0]      waddr;
	logic [EW-1:0]      wdata;
	logic [EW-1:0]      rdata;

	logic [ID_BITS-1:0] e_num;
	logic [31:0]        e_rem;
	logic [31:0]        e_per;
	logic               e_periodic;
	logic               e_marked;
	logic [32:0]        diff;
	logic [31:0]        sat_rem;
	logic               fired;
	logic               reload;
	logic               keep;
	logic               match;

	rpt_cmd_t           cmd;

	assign in_kind = kind_t'(kind);
	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign full    = (count_q >= CNT_W'(SLOTS));
	assign issue   = (state_q == S_WALK) && (rd_ptr_q < count_q) && !found_q;
	assign proc    = (state_q == S_WALK) && vld_s1;
	assign done    = (state_q == S_WALK) && !issue && !vld_s1;

	// id counter wraps at the id width and skips zero
	always_comb begin
		next_inc = next_q + ID_BITS'(1);
		if (next_inc == '0) begin
			next_inc = ID_BITS'(1);
		end
	end

	// entry layout: {id, remaining, period, periodic, marked}
	assign e_num      = rdata[EW-1 -: ID_BITS];
	assign e_rem      = rdata[65:34];
	assign e_per      = rdata[33:2];
	assign e_periodic = rdata[1];
	assign e_marked   = rdata[0];

	// saturating subtract of the elapsed time
	assign diff    = {e_rem[31], e_rem} - {2'b00, elapsed_q};
	assign sat_rem = (diff[32] && !diff[31]) ? 32'h8000_0000 : diff[31:0];
	assign fired   = sat_rem[31] || (sat_rem == 32'd0);
	assign reload  = e_periodic && !e_per[31] && (e_per != 32'd0);
	assign keep    = !e_marked && (!fired || reload);
	assign match   = (CW'(e_num) == CW'(target_q));

	// RAM write port: append on add, compact on tick, mark on cancel
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = rdata;
		priority if (accept && !full && (in_kind == K_ADD_ONE || in_kind == K_ADD_PER)) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = {next_q, first_delay,
				(in_kind == K_ADD_PER) ? period : 32'sd0,
				(in_kind == K_ADD_PER), 1'b0};
		end else if (proc && op_q == K_TICK) begin
			we    = keep;
			waddr = dst_q[AW-1:0];
			wdata = {e_num, fired ? e_per : sat_rem, e_per, e_periodic, 1'b0};
		end else if (proc && op_q == K_CAN_ALL) begin
			we    = 1'b1;
			waddr = src_s1;
			wdata = {rdata[EW-1:1], 1'b1};
		end else if (proc && op_q == K_CANCEL) begin
			we    = !found_q && match;
			waddr = src_s1;
			wdata = {rdata[EW-1:1], 1'b1};
		end
	end

	ttt_ram #(
		.WIDTH (EW),
		.DEPTH (SLOTS),
		.ADDR_W(AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	// requests to the result stage
	always_comb begin
		cmd.add_v  = accept && (in_kind == K_ADD_ONE || in_kind == K_ADD_PER);
		cmd.fire_v = proc && (op_q == K_TICK) && !e_marked && fired &&
			(fires_q < FIRE_W'(MAX_OUT));
		cmd.flush  = done && (op_q == K_TICK);
		if (cmd.add_v) begin
			cmd.number = full ? NUM_W'(0) : NUM_W'(next_q);
		end else begin
			cmd.number = NUM_W'(e_num);
		end
	end

	ttt_report u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.strobe     (strobe),
		.result_kind(result_kind),
		.task_number(task_number),
		.last       (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= K_TICK;
			count_q  <= '0;
			next_q   <= ID_BITS'(1);
			rd_ptr_q <= '0;
			dst_q    <= '0;
			found_q  <= 1'b0;
			fires_q  <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (state_q == S_IDLE) begin
				if (accept) begin
					op_q     <= in_kind;
					rd_ptr_q <= '0;
					dst_q    <= '0;
					found_q  <= 1'b0;
					fires_q  <= '0;
					unique case (in_kind)
						K_ADD_ONE, K_ADD_PER: begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
								next_q  <= next_inc;
							end
						end
						K_CLEAR: count_q <= '0;
						K_TICK, K_CANCEL, K_CAN_ALL: state_q <= S_WALK;
						default: ;
					endcase
				end
			end else begin
				// advance the read pointer, process the entry read last cycle
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				end
				if (proc && op_q == K_TICK && keep) begin
					dst_q <= dst_q + CNT_W'(1);
				end
				if (cmd.fire_v) begin
					fires_q <= fires_q + FIRE_W'(1);
				end
				if (proc && op_q == K_CANCEL && match) begin
					found_q <= 1'b1;
				end
				if (done) begin
					if (op_q == K_TICK) begin
						count_q <= dst_q;
					end
					state_q <= S_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			src_s1 <= rd_ptr_q[AW-1:0];
		end
		if (accept) begin
			elapsed_q <= elapsed;
			target_q  <= target_id;
		end
	end

	`ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CNT_W'(SLOTS))
	`ASSERT_ALWAYS(a_next_nonzero, clk, arst_n, next_q != '0)
	`ASSERT_ALWAYS(a_dst_behind, clk, arst_n, dst_q <= rd_ptr_q)
	`ASSERT_IMPLIES(a_fire_tick, clk, arst_n, cmd.fire_v, op_q == K_TICK && state_q == S_WALK)
	`ASSERT_IMPLIES(a_walk_bound, clk, arst_n, state_q == S_WALK, rd_ptr_q <= count_q)

endmodule

[rtl/ttt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ttt_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/ttt_report.sv]
// ----------------------------------------------------------------------------
// Timer task table result stage
// Holds back one fired id so the final beat of a tick can carry last.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttt_report
	import ttt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  rpt_cmd_t         cmd,
	output logic             strobe,
	output logic             result_kind,
	output logic [NUM_W-1:0] task_number,
	output logic             last
);

	logic             pend_v_q;
	logic [NUM_W-1:0] pend_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe   <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			priority if (cmd.add_v) begin
				strobe      <= 1'b1;
				result_kind <= 1'b1;
				task_number <= cmd.number;
				last        <= 1'b1;
			end else if (cmd.fire_v) begin
				// emit the held id, hold the new one
				strobe      <= pend_v_q;
				result_kind <= 1'b0;
				task_number <= pend_id_q;
				last        <= 1'b0;
				pend_v_q    <= 1'b1;
				pend_id_q   <= cmd.number;
			end else if (cmd.flush) begin
				strobe      <= pend_v_q;
				result_kind <= 1'b0;
				task_number <= pend_id_q;
				last        <= 1'b1;
				pend_v_q    <= 1'b0;
			end
		end
	end

	`ASSERT_ALWAYS(a_fire_flush, clk, arst_n, !(cmd.fire_v && cmd.flush))
	`ASSERT_ALWAYS(a_add_fire, clk, arst_n, !(cmd.add_v && cmd.fire_v))
	`ASSERT_IMPLIES(a_add_clean, clk, arst_n, cmd.add_v, !pend_v_q)

endmodule
